// ===== hw/rtl/srfr_pkg.sv =====
// shared types, constants and codes of the servo reply frame receiver
// no dependencies; used by srfr_ctrl, srfr_dp and the top level

package srfr_pkg;

	// sizes
	localparam int BUFFER_BYTES = 32;
	localparam int SLOTS        = 8;
	localparam int BUF_AW       = $clog2(BUFFER_BYTES);
	localparam int SLOT_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;

	// frame constants
	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] MIN_LEN     = 8'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_IDS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd1;

	// result kinds
	typedef enum logic [2:0] {
		KIND_COPY       = 3'd0,
		KIND_EMPTY      = 3'd1,
		KIND_HELD       = 3'd2,
		KIND_BAD_HEADER = 3'd3,
		KIND_BAD_SUM    = 3'd4,
		KIND_UNKNOWN_ID = 3'd5,
		KIND_TOO_LONG   = 3'd6,
		KIND_BAD_LEN    = 3'd7
	} kind_t;

	// framing phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD2,
		PH_ID,
		PH_LEN,
		PH_BODY,
		PH_CHECK,
		PH_DEAD
	} phase_t;

	// sequencer state
	typedef enum logic [1:0] {
		CS_ACCEPT,
		CS_PROC,
		CS_READ,
		CS_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
		logic       hold_copy;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] servo_id;
		logic [2:0] slot;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic       last;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  take_in;
		logic  clr_frame;
		logic  ld_id;
		logic  ld_len;
		logic  ld_body;
		logic  rd_first;
		logic  rd_en;
		logic  rd_next;
		logic  out_load;
		logic  out_from_mem;
		logic  slot_en;
		kind_t kind;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic start;
		logic hold;
		logic byte_ff;
		logic len_bad;
		logic body_done;
		logic sum_ok;
		logic id_hit;
		logic too_long;
		logic len_two;
		logic run_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/srfr_ctrl.sv =====
// controller of the servo reply frame receiver: framing phase and sequencer
// depends on srfr_pkg; drives commands into srfr_dp

module srfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  srfr_pkg::dp_sts_t sts,
	output srfr_pkg::dp_cmd_t cmd
);

	srfr_pkg::ctl_state_t state_q, state_d;
	srfr_pkg::phase_t     phase_q, phase_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srfr_pkg::CS_ACCEPT;
			phase_q <= srfr_pkg::PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		cmd.kind = srfr_pkg::KIND_COPY;
		in_stall = 1'b1;
		case (state_q)
			srfr_pkg::CS_ACCEPT: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = srfr_pkg::CS_PROC;
				end
			end
			srfr_pkg::CS_PROC: begin
				// frame start restarts framing from any phase
				if (sts.start) begin
					if (!sts.byte_ff) begin
						if (sts.out_free) begin
							cmd.clr_frame = 1'b1;
							cmd.out_load  = 1'b1;
							cmd.kind      = srfr_pkg::KIND_BAD_HEADER;
							phase_d       = srfr_pkg::PH_DEAD;
							state_d       = srfr_pkg::CS_ACCEPT;
						end
					end else begin
						cmd.clr_frame = 1'b1;
						phase_d       = srfr_pkg::PH_HEAD2;
						state_d       = srfr_pkg::CS_ACCEPT;
					end
				end else begin
					case (phase_q)
						srfr_pkg::PH_HEAD2: begin
							if (!sts.byte_ff) begin
								if (sts.out_free) begin
									cmd.out_load = 1'b1;
									cmd.kind     = srfr_pkg::KIND_BAD_HEADER;
									phase_d      = srfr_pkg::PH_DEAD;
									state_d      = srfr_pkg::CS_ACCEPT;
								end
							end else begin
								phase_d = srfr_pkg::PH_ID;
								state_d = srfr_pkg::CS_ACCEPT;
							end
						end
						srfr_pkg::PH_ID: begin
							cmd.ld_id = 1'b1;
							phase_d   = srfr_pkg::PH_LEN;
							state_d   = srfr_pkg::CS_ACCEPT;
						end
						srfr_pkg::PH_LEN: begin
							if (sts.len_bad) begin
								if (sts.out_free) begin
									cmd.out_load = 1'b1;
									cmd.kind     = srfr_pkg::KIND_BAD_LEN;
									phase_d      = srfr_pkg::PH_DEAD;
									state_d      = srfr_pkg::CS_ACCEPT;
								end
							end else begin
								cmd.ld_len = 1'b1;
								phase_d    = srfr_pkg::PH_BODY;
								state_d    = srfr_pkg::CS_ACCEPT;
							end
						end
						srfr_pkg::PH_BODY: begin
							cmd.ld_body = 1'b1;
							if (sts.body_done) begin
								phase_d = srfr_pkg::PH_CHECK;
							end
							state_d = srfr_pkg::CS_ACCEPT;
						end
						srfr_pkg::PH_CHECK: begin
							// checks in priority order; a clean frame starts the copy run
							if (!sts.sum_ok || !sts.id_hit || sts.too_long || sts.len_two
									|| sts.hold) begin
								if (sts.out_free) begin
									cmd.out_load = 1'b1;
									cmd.slot_en  = sts.sum_ok && sts.id_hit;
									if (!sts.sum_ok) begin
										cmd.kind = srfr_pkg::KIND_BAD_SUM;
									end else if (!sts.id_hit) begin
										cmd.kind = srfr_pkg::KIND_UNKNOWN_ID;
									end else if (sts.too_long) begin
										cmd.kind = srfr_pkg::KIND_TOO_LONG;
									end else if (sts.len_two) begin
										cmd.kind = srfr_pkg::KIND_EMPTY;
									end else begin
										cmd.kind = srfr_pkg::KIND_HELD;
									end
									phase_d = srfr_pkg::PH_IDLE;
									state_d = srfr_pkg::CS_ACCEPT;
								end
							end else begin
								cmd.rd_first = 1'b1;
								phase_d      = srfr_pkg::PH_IDLE;
								state_d      = srfr_pkg::CS_READ;
							end
						end
						default: begin
							state_d = srfr_pkg::CS_ACCEPT;
						end
					endcase
				end
			end
			srfr_pkg::CS_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = srfr_pkg::CS_EMIT;
			end
			srfr_pkg::CS_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.slot_en      = 1'b1;
					cmd.rd_next      = 1'b1;
					state_d          = sts.run_last ? srfr_pkg::CS_ACCEPT : srfr_pkg::CS_READ;
				end
			end
			default: begin
				state_d = srfr_pkg::CS_ACCEPT;
			end
		endcase
	end

endmodule

// ===== hw/rtl/srfr_dp.sv =====
// datapath of the servo reply frame receiver: input latch, frame registers,
// frame buffer, slot lookup, configuration registers and output register
// depends on srfr_pkg; controlled by srfr_ctrl

module srfr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srfr_pkg::in_item_t                  in_item,
	input  logic                                cfg_valid,
	input  logic [srfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output srfr_pkg::out_item_t                 out_item,
	input  srfr_pkg::dp_cmd_t                   cmd,
	output srfr_pkg::dp_sts_t                   sts
);

	srfr_pkg::in_item_t                  in_q;
	logic [srfr_pkg::CFG_DATA_W-1:0]     slot_ids_q;
	logic [3:0]                          slot_count_q;
	logic [7:0]                          sum_q;
	logic [7:0]                          len_q;
	logic [7:0]                          seen_q;
	logic [7:0]                          id_q;
	logic [srfr_pkg::BUF_AW-1:0]         idx_q;
	logic [7:0]                          rd_data_q;
	logic                                out_valid_q;
	srfr_pkg::out_item_t                 out_q;
	logic [7:0]                          mem [srfr_pkg::BUFFER_BYTES];

	logic                                mem_we;
	logic [srfr_pkg::BUF_AW-1:0]         mem_wa;
	logic                                seen_in_buf;
	logic                                hit;
	logic [srfr_pkg::SLOT_W-1:0]         hit_slot;
	logic [8:0]                          seen_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ids_q   <= '0;
			slot_count_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == srfr_pkg::REG_SLOT_IDS) begin
				slot_ids_q <= cfg_data;
			end else if (cfg_index == srfr_pkg::REG_SLOT_COUNT) begin
				slot_count_q <= cfg_data[3:0];
			end
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			in_q <= in_item;
		end
	end

	// frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			len_q  <= '0;
			seen_q <= '0;
			id_q   <= '0;
		end else if (cmd.clr_frame) begin
			sum_q  <= '0;
			len_q  <= '0;
			seen_q <= '0;
			id_q   <= '0;
		end else if (cmd.ld_id) begin
			id_q  <= in_q.rx_byte;
			sum_q <= in_q.rx_byte;
		end else if (cmd.ld_len) begin
			len_q  <= in_q.rx_byte;
			sum_q  <= sum_q + in_q.rx_byte;
			seen_q <= 8'd1;
		end else if (cmd.ld_body) begin
			sum_q  <= sum_q + in_q.rx_byte;
			seen_q <= seen_q + 8'd1;
		end
	end

	// frame buffer write: length byte at entry zero, body while it fits
	assign seen_in_buf = {1'b0, seen_q} < 9'(srfr_pkg::BUFFER_BYTES);
	assign mem_we      = cmd.ld_len || (cmd.ld_body && seen_in_buf);
	assign mem_wa      = cmd.ld_len ? '0 : seen_q[srfr_pkg::BUF_AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= in_q.rx_byte;
		end
	end

	// frame buffer read, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// copy run index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.rd_first) begin
			idx_q <= '0;
		end else if (cmd.rd_next) begin
			idx_q <= idx_q + srfr_pkg::BUF_AW'(1);
		end
	end

	// slot lookup, lowest matching slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int k = srfr_pkg::SLOTS - 1; k >= 0; k--) begin
			if ((4'(k) < slot_count_q) && (slot_ids_q[8*k +: 8] == id_q)) begin
				hit      = 1'b1;
				hit_slot = srfr_pkg::SLOT_W'(k);
			end
		end
	end

	// status
	assign seen_inc = {1'b0, seen_q} + 9'd1;

	always_comb begin
		sts.start     = in_q.frame_start;
		sts.hold      = in_q.hold_copy;
		sts.byte_ff   = in_q.rx_byte == srfr_pkg::HEADER_BYTE;
		sts.len_bad   = in_q.rx_byte < srfr_pkg::MIN_LEN;
		sts.body_done = seen_inc >= {1'b0, len_q};
		sts.sum_ok    = in_q.rx_byte == ~sum_q;
		sts.id_hit    = hit;
		sts.too_long  = {1'b0, len_q} >= 9'(srfr_pkg::BUFFER_BYTES);
		sts.len_two   = len_q == srfr_pkg::MIN_LEN;
		sts.run_last  = (8'(idx_q) + 8'd1) == len_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.kind       <= cmd.kind;
			out_q.servo_id   <= (cmd.kind == srfr_pkg::KIND_BAD_HEADER) ? 8'd0 : id_q;
			out_q.slot       <= cmd.slot_en ? hit_slot : '0;
			out_q.data_byte  <= cmd.out_from_mem ? rd_data_q : 8'd0;
			out_q.byte_index <= cmd.out_from_mem ? 6'(idx_q) : 6'd0;
			out_q.last       <= cmd.out_from_mem ? sts.run_last : 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== hw/rtl/servo_reply_frame_receiver_top.sv =====
// top level of the servo reply frame receiver
// depends on srfr_pkg; instantiates srfr_ctrl and srfr_dp
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_item (rx_byte, frame_start, hold_copy)
//  out      output     out_valid/out_stall out_item (kind .. last)
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// each byte is first latched from the beat, then processed
// a clean frame at its checksum byte then copies each buffered byte
// through the buffer read port, then the output register
// a pending result does not block the next beat; a stalled output only
// holds the byte in process that needs the output register
// reset clears framing, frame registers and configuration; no buffer clearing

module servo_reply_frame_receiver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  srfr_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output srfr_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	srfr_pkg::dp_cmd_t cmd;
	srfr_pkg::dp_sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	srfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	srfr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
